@@ sv/php_pkg.sv @@
// shared types and protocol codes for the packet header parser
package php_pkg;

    localparam int PHP_MAX_VLAN_TAGS = 15;

    localparam logic [15:0] CODE_IPV4      = 16'h0800;
    localparam logic [15:0] CODE_IPIP      = 16'h0004;
    localparam logic [15:0] CODE_ARP       = 16'h0806;
    localparam logic [15:0] CODE_VLAN      = 16'h8100;
    localparam logic [15:0] CODE_MPLS_UC   = 16'h8847;
    localparam logic [15:0] CODE_MPLS_MC   = 16'h8848;
    localparam logic [15:0] CODE_GRE       = 16'd47;
    localparam logic [15:0] CODE_ICMP      = 16'd1;
    localparam logic [15:0] CODE_TCP       = 16'd6;
    localparam logic [15:0] CODE_UDP       = 16'd17;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic [15:0] frame_length;
        logic        last_byte;
    } php_in_t;

    typedef struct packed {
        logic [15:0] ip_offset;
        logic [15:0] payload_offset;
        logic [15:0] payload_length;
        logic        payload_found;
        logic        ip_truncated;
        logic [3:0]  vlan_count;
        logic        header_overrun;
    } php_out_t;

endpackage

@@ sv/php_in_stage.sv @@
// input register for frame bytes
module php_in_stage (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  php_pkg::php_in_t s_item,
    input  logic             take,
    output logic             item_valid,
    output php_pkg::php_in_t item
);

    logic             valid_reg;
    logic             valid_next;
    php_pkg::php_in_t item_reg;

    assign s_ready    = !valid_reg || take;
    assign valid_next = s_ready ? s_valid : valid_reg;
    assign item_valid = valid_reg;
    assign item       = item_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            item_reg <= s_item;
        end
    end

endmodule

@@ sv/php_walker.sv @@
// header walk state and per-byte update
module php_walker #(
    parameter int MAX_VLAN_TAGS = php_pkg::PHP_MAX_VLAN_TAGS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              take,
    input  php_pkg::php_in_t  item,
    output php_pkg::php_out_t result
);

    localparam logic [3:0] TagCap = (MAX_VLAN_TAGS < 15) ? 4'(MAX_VLAN_TAGS) : 4'd15;

    localparam logic [3:0] KIND_ETH     = 4'd0;
    localparam logic [3:0] KIND_VLAN    = 4'd1;
    localparam logic [3:0] KIND_MPLS    = 4'd2;
    localparam logic [3:0] KIND_IP      = 4'd3;
    localparam logic [3:0] KIND_GRE     = 4'd4;
    localparam logic [3:0] KIND_ARP     = 4'd5;
    localparam logic [3:0] KIND_ICMP    = 4'd6;
    localparam logic [3:0] KIND_TCP     = 4'd7;
    localparam logic [3:0] KIND_UDP     = 4'd8;
    localparam logic [3:0] KIND_PAYLOAD = 4'd9;
    localparam logic [3:0] KIND_STOP    = 4'd10;

    logic [15:0] pos_reg, pos_next;
    logic [3:0]  kind_reg, kind_next;
    logic [15:0] hstart_reg, hstart_next;
    logic [7:0]  left_reg, left_next;
    logic [15:0] code_reg, code_next;
    logic [15:0] iptot_reg, iptot_next;
    logic [15:0] ipoff_reg, ipoff_next;
    logic [15:0] payoff_reg, payoff_next;
    logic [3:0]  tags_reg, tags_next;
    logic        trunc_reg, trunc_next;
    logic        over_reg, over_next;

    logic [15:0] fl;
    logic [7:0]  d;
    logic        active;
    logic [15:0] off;
    logic [15:0] rem;
    logic [7:0]  left;
    logic        early_end;
    logic [15:0] es;
    logic [15:0] er;
    logic [16:0] es_plus8;
    logic [1:0]  gre_n;
    logic [4:0]  gre_hl;
    logic [15:0] ip_tot;
    logic [17:0] ip_hl;
    logic [5:0]  tcp_hl;
    logic [16:0] tcp_end;
    logic [15:0] enter_code;
    logic        found;

    assign fl       = item.frame_length;
    assign d        = item.data_byte;
    assign active   = (pos_reg < fl) && (kind_reg != KIND_PAYLOAD) && (kind_reg != KIND_STOP);
    assign off      = pos_reg - hstart_reg;
    assign rem      = fl - hstart_reg;
    assign es       = pos_reg + 16'd1;
    assign er       = fl - es;
    assign es_plus8 = {1'b0, es} + 17'd8;
    assign gre_n    = {1'b0, d[7]} + {1'b0, d[5]} + {1'b0, d[4]};
    assign gre_hl   = 5'd4 + {1'b0, gre_n, 2'b00};
    assign ip_tot   = iptot_reg | {8'h00, d};
    assign ip_hl    = {code_reg, 2'b00};
    assign tcp_hl   = {d[7:4], 2'b00};
    assign tcp_end  = {1'b0, hstart_reg} + {11'b0, tcp_hl};

    always_comb begin
        pos_next    = (pos_reg != 16'hFFFF) ? pos_reg + 16'd1 : pos_reg;
        kind_next   = kind_reg;
        hstart_next = hstart_reg;
        left_next   = left_reg;
        code_next   = code_reg;
        iptot_next  = iptot_reg;
        ipoff_next  = ipoff_reg;
        payoff_next = payoff_reg;
        tags_next   = tags_reg;
        trunc_next  = trunc_reg;
        over_next   = over_reg;
        left        = left_reg - 8'd1;
        early_end   = 1'b0;
        enter_code  = code_reg;

        if (active) begin
            case (kind_reg)
                KIND_ETH: begin
                    if (off == 16'd0 && fl <= 16'd14) begin
                        kind_next = KIND_STOP;
                        over_next = over_reg || (fl < 16'd14);
                        early_end = 1'b1;
                    end else begin
                        if (off == 16'd12) code_next = {d, 8'h00};
                        if (off == 16'd13) code_next = code_reg | {8'h00, d};
                    end
                end
                KIND_VLAN: begin
                    if (off == 16'd2) code_next = {d, 8'h00};
                    if (off == 16'd3) code_next = code_reg | {8'h00, d};
                end
                KIND_GRE: begin
                    if (off == 16'd0 && {11'b0, gre_hl} > rem) begin
                        kind_next = KIND_STOP;
                        over_next = 1'b1;
                        early_end = 1'b1;
                    end else begin
                        if (off == 16'd0) left = {3'b000, gre_hl} - 8'd1;
                        if (off == 16'd2) code_next = {d, 8'h00};
                        if (off == 16'd3) code_next = code_reg | {8'h00, d};
                    end
                end
                KIND_IP: begin
                    if (off == 16'd0) code_next = {12'h000, d[3:0]};
                    if (off == 16'd2) iptot_next = {d, 8'h00};
                    if (off == 16'd3) begin
                        iptot_next = ip_tot;
                        if (rem < ip_tot) begin
                            trunc_next = 1'b1;
                            kind_next  = KIND_STOP;
                            early_end  = 1'b1;
                        end else if (ip_hl < 18'd20) begin
                            kind_next = KIND_STOP;
                            early_end = 1'b1;
                        end else if (ip_hl > {2'b00, rem}) begin
                            kind_next = KIND_STOP;
                            over_next = 1'b1;
                            early_end = 1'b1;
                        end else begin
                            left = ip_hl[7:0] - 8'd4;
                        end
                    end
                    if (off == 16'd9) code_next = {8'h00, d};
                end
                KIND_TCP: begin
                    if (off == 16'd12) begin
                        if (tcp_hl < 6'd20) begin
                            kind_next = KIND_STOP;
                            early_end = 1'b1;
                        end else if ({10'b0, tcp_hl} > rem) begin
                            payoff_next = tcp_end[16] ? 16'hFFFF : tcp_end[15:0];
                            kind_next   = KIND_PAYLOAD;
                            over_next   = 1'b1;
                            early_end   = 1'b1;
                        end else begin
                            left = {2'b00, tcp_hl} - 8'd13;
                        end
                    end
                end
                default: begin
                end
            endcase

            if (!early_end) begin
                left_next = left;
                if (left == 8'd0) begin
                    if (kind_reg == KIND_ARP || kind_reg == KIND_ICMP ||
                        kind_reg == KIND_UDP || kind_reg == KIND_TCP) begin
                        payoff_next = es;
                        kind_next   = KIND_PAYLOAD;
                    end else begin
                        enter_code  = (kind_reg == KIND_MPLS) ? php_pkg::CODE_IPV4 : code_next;
                        hstart_next = es;
                        case (enter_code)
                            php_pkg::CODE_IPV4, php_pkg::CODE_IPIP: begin
                                ipoff_next = es;
                                left_next  = 8'd4;
                                if (er < 16'd4) begin
                                    kind_next = KIND_STOP;
                                    over_next = 1'b1;
                                end else begin
                                    kind_next = KIND_IP;
                                end
                            end
                            php_pkg::CODE_ARP: begin
                                if (er <= 16'd28) begin
                                    kind_next = KIND_STOP;
                                    over_next = over_reg || (er < 16'd28);
                                end else begin
                                    kind_next = KIND_ARP;
                                    left_next = 8'd28;
                                end
                            end
                            php_pkg::CODE_VLAN: begin
                                if (er <= 16'd4) begin
                                    kind_next = KIND_STOP;
                                    over_next = over_reg || (er < 16'd4);
                                end else begin
                                    kind_next = KIND_VLAN;
                                    left_next = 8'd4;
                                    if (tags_reg < TagCap) tags_next = tags_reg + 4'd1;
                                end
                            end
                            php_pkg::CODE_MPLS_UC, php_pkg::CODE_MPLS_MC: begin
                                if (er < 16'd4) begin
                                    kind_next = KIND_STOP;
                                    over_next = 1'b1;
                                end else begin
                                    kind_next = KIND_MPLS;
                                    left_next = 8'd4;
                                end
                            end
                            php_pkg::CODE_GRE: begin
                                if (er <= 16'd4) begin
                                    kind_next = KIND_STOP;
                                    over_next = over_reg || (er < 16'd4);
                                end else begin
                                    kind_next = KIND_GRE;
                                    left_next = 8'd4;
                                end
                            end
                            php_pkg::CODE_ICMP, php_pkg::CODE_UDP: begin
                                if (er < 16'd8) begin
                                    payoff_next = es_plus8[16] ? 16'hFFFF : es_plus8[15:0];
                                    kind_next   = KIND_PAYLOAD;
                                    over_next   = 1'b1;
                                end else begin
                                    kind_next = (enter_code == php_pkg::CODE_ICMP) ?
                                                KIND_ICMP : KIND_UDP;
                                    left_next = 8'd8;
                                end
                            end
                            php_pkg::CODE_TCP: begin
                                if (er < 16'd13) begin
                                    kind_next = KIND_STOP;
                                    over_next = 1'b1;
                                end else begin
                                    kind_next = KIND_TCP;
                                    left_next = 8'd13;
                                end
                            end
                            default: begin
                                payoff_next = es;
                                kind_next   = KIND_PAYLOAD;
                            end
                        endcase
                    end
                end
            end
        end
    end

    // result as seen after this byte
    assign found = (kind_next == KIND_PAYLOAD);

    always_comb begin
        result.ip_offset      = ipoff_next;
        result.payload_offset = found ? payoff_next : 16'd0;
        result.payload_length = (found && fl > payoff_next) ? fl - payoff_next : 16'd0;
        result.payload_found  = found;
        result.ip_truncated   = trunc_next;
        result.vlan_count     = tags_next;
        result.header_overrun = over_next ||
                                (kind_next != KIND_PAYLOAD && kind_next != KIND_STOP);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (take && item.last_byte)) begin
            pos_reg    <= 16'd0;
            kind_reg   <= KIND_ETH;
            hstart_reg <= 16'd0;
            left_reg   <= 8'd14;
            code_reg   <= 16'd0;
            iptot_reg  <= 16'd0;
            ipoff_reg  <= 16'd0;
            payoff_reg <= 16'd0;
            tags_reg   <= 4'd0;
            trunc_reg  <= 1'b0;
            over_reg   <= 1'b0;
        end else if (take) begin
            pos_reg    <= pos_next;
            kind_reg   <= kind_next;
            hstart_reg <= hstart_next;
            left_reg   <= left_next;
            code_reg   <= code_next;
            iptot_reg  <= iptot_next;
            ipoff_reg  <= ipoff_next;
            payoff_reg <= payoff_next;
            tags_reg   <= tags_next;
            trunc_reg  <= trunc_next;
            over_reg   <= over_next;
        end
    end

endmodule

@@ sv/packet_header_parser.sv @@
// Streaming Ethernet header parser: takes one frame byte per clock unless stalled, and
// walks Ethernet, 802.1Q, MPLS, IPv4, GRE, ARP, ICMP, TCP and UDP headers. Each byte
// passes an input register and is folded into the walk state by the walker; the
// result for a frame is written to the output register when its last byte leaves the
// input register, and may wait there while the next frame streams in.
// The input side stalls only when a last byte meets a result not yet taken.
module packet_header_parser #(
    parameter int MAX_VLAN_TAGS = php_pkg::PHP_MAX_VLAN_TAGS
) (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  php_pkg::php_in_t  s_item,
    output logic              m_valid,
    input  logic              m_ready,
    output php_pkg::php_out_t m_item
);

    logic              item_valid;
    php_pkg::php_in_t  item;
    logic              take;
    php_pkg::php_out_t result;
    logic              m_valid_reg, m_valid_next;
    php_pkg::php_out_t m_item_reg;

    // a last byte needs room in the output register
    assign take = item_valid && (!item.last_byte || !m_valid_reg || m_ready);

    php_in_stage u_in_stage (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_item     (s_item),
        .take       (take),
        .item_valid (item_valid),
        .item       (item)
    );

    php_walker #(
        .MAX_VLAN_TAGS (MAX_VLAN_TAGS)
    ) u_walker (
        .aclk    (aclk),
        .aresetn (aresetn),
        .take    (take),
        .item    (item),
        .result  (result)
    );

    assign m_valid_next = (take && item.last_byte) || (m_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (take && item.last_byte) begin
            m_item_reg <= result;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

@@ sv/php_checker.sv @@
// port-level checks for the packet header parser, with bind
module php_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input php_pkg::php_in_t  s_item,
    input logic              m_valid,
    input logic              m_ready,
    input php_pkg::php_out_t m_item
);

    logic [16:0] pay_end;

    assign pay_end = {1'b0, m_item.payload_offset} + {1'b0, m_item.payload_length};

    a_reset_clears_result: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_input_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_item))
        else $error("waiting input item changed");

    a_result_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_item))
        else $error("stalled result changed");

    a_no_payload_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_item.payload_found |->
            m_item.payload_offset == 16'd0 && m_item.payload_length == 16'd0)
        else $error("payload fields set without payload");

    a_payload_in_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_item.payload_length != 16'd0 |-> pay_end <= 17'h0FFFF)
        else $error("payload runs past largest frame");

endmodule

bind packet_header_parser php_checker u_php_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .s_item  (s_item),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_item  (m_item)
);

@@ tb/tb_packet_header_parser.sv @@
// testbench for packet_header_parser: random and directed frames checked against a header walk
`timescale 1ns / 100ps

module tb_packet_header_parser;

    localparam int TAG_CAP = (php_pkg::PHP_MAX_VLAN_TAGS < 15) ?
                             php_pkg::PHP_MAX_VLAN_TAGS : 15;
    localparam int STALL_LIMIT = 5000;
    localparam logic [15:0] CODE_UNKNOWN   = 16'h88B5;
    localparam logic [15:0] CODE_STACK_END = 16'h9000;

    typedef enum logic [3:0] {
        HK_ETH, HK_VLAN, HK_MPLS, HK_IP, HK_GRE, HK_ARP, HK_ICMP, HK_TCP, HK_UDP,
        HK_PAYLOAD, HK_STOP
    } walk_kind_t;

    typedef enum int {TL_EXACT, TL_LONG, TL_RANDOM} tot_len_mode_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    php_pkg::php_in_t  s_item = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    php_pkg::php_out_t m_item;

    php_pkg::php_in_t  bytes_to_send[$];
    php_pkg::php_out_t reports_due[$];
    logic [7:0]        frame_buf[$];
    int                ip_starts[$];
    logic              s_took = 1'b0;
    int unsigned       tx_idle_pct = 0;
    int unsigned       rx_idle_pct = 0;
    int                idle_cycles = 0;
    int                mismatch_count = 0;
    int                results_checked = 0;
    int                frames_sent = 0;
    int                bytes_sent = 0;

    // header walk state
    logic [15:0] walk_pos;
    walk_kind_t  hdr_kind;
    logic [15:0] hdr_start;
    logic [7:0]  hdr_left;
    logic [15:0] code_acc;
    logic [15:0] ip_tot_len;
    logic [15:0] ip_off_q;
    logic [15:0] pay_off_q;
    logic [3:0]  tags_seen;
    logic        trunc_f;
    logic        over_f;

    packet_header_parser dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    task automatic clear_walk();
        walk_pos = '0;
        hdr_kind = HK_ETH;
        hdr_start = '0;
        hdr_left = 8'd14;
        code_acc = '0;
        ip_tot_len = '0;
        ip_off_q = '0;
        pay_off_q = '0;
        tags_seen = '0;
        trunc_f = 1'b0;
        over_f = 1'b0;
    endtask

    task automatic stop_walk(input bit over);
        hdr_kind = HK_STOP;
        if (over) over_f = 1'b1;
    endtask

    task automatic mark_payload(input int off, input bit over);
        if (off > 65535) off = 65535;
        pay_off_q = 16'(off);
        hdr_kind = HK_PAYLOAD;
        if (over) over_f = 1'b1;
    endtask

    task automatic enter_hdr(input logic [15:0] code, input int start, input int fl);
        int rem;
        rem = (start < fl) ? fl - start : 0;
        hdr_start = 16'(start);
        case (code)
            php_pkg::CODE_IPV4, php_pkg::CODE_IPIP: begin
                ip_off_q = 16'(start);
                hdr_kind = HK_IP;
                hdr_left = 8'd4;
                if (rem < 4) stop_walk(1);
            end
            php_pkg::CODE_ARP: begin
                if (rem <= 28) stop_walk(rem < 28);
                else begin
                    hdr_kind = HK_ARP;
                    hdr_left = 8'd28;
                end
            end
            php_pkg::CODE_VLAN: begin
                if (rem <= 4) stop_walk(rem < 4);
                else begin
                    hdr_kind = HK_VLAN;
                    hdr_left = 8'd4;
                    if (tags_seen < TAG_CAP) tags_seen++;
                end
            end
            php_pkg::CODE_MPLS_UC, php_pkg::CODE_MPLS_MC: begin
                if (rem < 4) stop_walk(1);
                else begin
                    hdr_kind = HK_MPLS;
                    hdr_left = 8'd4;
                end
            end
            php_pkg::CODE_GRE: begin
                if (rem <= 4) stop_walk(rem < 4);
                else begin
                    hdr_kind = HK_GRE;
                    hdr_left = 8'd4;
                end
            end
            php_pkg::CODE_ICMP, php_pkg::CODE_UDP: begin
                if (rem < 8) mark_payload(start + 8, 1);
                else begin
                    hdr_kind = (code == php_pkg::CODE_ICMP) ? HK_ICMP : HK_UDP;
                    hdr_left = 8'd8;
                end
            end
            php_pkg::CODE_TCP: begin
                if (rem < 13) stop_walk(1);
                else begin
                    hdr_kind = HK_TCP;
                    hdr_left = 8'd13;
                end
            end
            default: mark_payload(start, 0);
        endcase
    endtask

    task automatic parse_byte(input logic [7:0] d, input int pos, input int fl);
        int off;
        int rem;
        int hl;
        logic [7:0] left;
        off = (pos - int'(hdr_start)) & 'hFFFF;
        rem = fl - int'(hdr_start);
        left = hdr_left - 8'd1;
        case (hdr_kind)
            HK_ETH: begin
                if (off == 0 && fl <= 14) begin
                    stop_walk(fl < 14);
                    return;
                end
                if (off == 12) code_acc = {d, 8'h00};
                if (off == 13) code_acc[7:0] = d;
            end
            HK_VLAN: begin
                if (off == 2) code_acc = {d, 8'h00};
                if (off == 3) code_acc[7:0] = d;
            end
            HK_GRE: begin
                if (off == 0) begin
                    hl = 4 + 4 * (int'(d[7]) + int'(d[5]) + int'(d[4]));
                    if (hl > rem) begin
                        stop_walk(1);
                        return;
                    end
                    left = 8'(hl - 1);
                end
                if (off == 2) code_acc = {d, 8'h00};
                if (off == 3) code_acc[7:0] = d;
            end
            HK_IP: begin
                if (off == 0) code_acc = {12'h000, d[3:0]};
                if (off == 2) ip_tot_len = {d, 8'h00};
                if (off == 3) begin
                    ip_tot_len[7:0] = d;
                    hl = int'(code_acc) * 4;
                    if (rem < int'(ip_tot_len)) begin
                        trunc_f = 1'b1;
                        stop_walk(0);
                        return;
                    end
                    if (hl < 20) begin
                        stop_walk(0);
                        return;
                    end
                    if (hl > rem) begin
                        stop_walk(1);
                        return;
                    end
                    left = 8'(hl - 4);
                end
                if (off == 9) code_acc = {8'h00, d};
            end
            HK_TCP: begin
                if (off == 12) begin
                    hl = int'(d[7:4]) * 4;
                    if (hl < 20) begin
                        stop_walk(0);
                        return;
                    end
                    if (hl > rem) begin
                        mark_payload(int'(hdr_start) + hl, 1);
                        return;
                    end
                    left = 8'(hl - 13);
                end
            end
            default: ;
        endcase
        hdr_left = left;
        if (left != 0) return;
        case (hdr_kind)
            HK_MPLS: enter_hdr(php_pkg::CODE_IPV4, pos + 1, fl);
            HK_ARP, HK_ICMP, HK_UDP, HK_TCP: mark_payload(pos + 1, 0);
            default: enter_hdr(code_acc, pos + 1, fl);
        endcase
    endtask

    task automatic predict_item(input php_pkg::php_in_t it);
        int pos;
        int fl;
        bit found;
        php_pkg::php_out_t r;
        pos = int'(walk_pos);
        fl = int'(it.frame_length);
        if (pos < fl && hdr_kind != HK_PAYLOAD && hdr_kind != HK_STOP)
            parse_byte(it.data_byte, pos, fl);
        if (walk_pos != 16'hFFFF) walk_pos++;
        if (!it.last_byte) return;
        found = (hdr_kind == HK_PAYLOAD);
        r.ip_offset = ip_off_q;
        r.payload_offset = found ? pay_off_q : 16'd0;
        r.payload_length = (found && fl > int'(pay_off_q)) ? 16'(fl - int'(pay_off_q)) : 16'd0;
        r.payload_found = found;
        r.ip_truncated = trunc_f;
        r.vlan_count = tags_seen;
        r.header_overrun = over_f || (hdr_kind != HK_PAYLOAD && hdr_kind != HK_STOP);
        reports_due.insert(reports_due.size(), r);
        clear_walk();
    endtask

    task automatic check_field(input string name, input logic [15:0] want,
                               input logic [15:0] got);
        if (want !== got) begin
            mismatch_count++;
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
        end
    endtask

    task automatic check_report(input php_pkg::php_out_t got);
        php_pkg::php_out_t want;
        if (reports_due.size() == 0) begin
            mismatch_count++;
            $display("%0t: result with nothing expected, expected none, got %h", $time, got);
            return;
        end
        want = reports_due.pop_front();
        results_checked++;
        check_field("ip_offset", want.ip_offset, got.ip_offset);
        check_field("payload_offset", want.payload_offset, got.payload_offset);
        check_field("payload_length", want.payload_length, got.payload_length);
        check_field("payload_found", 16'(want.payload_found), 16'(got.payload_found));
        check_field("ip_truncated", 16'(want.ip_truncated), 16'(got.ip_truncated));
        check_field("vlan_count", 16'(want.vlan_count), 16'(got.vlan_count));
        check_field("header_overrun", 16'(want.header_overrun), 16'(got.header_overrun));
    endtask

    // frame building
    task automatic add_byte(input logic [7:0] b);
        frame_buf.insert(frame_buf.size(), b);
    endtask

    task automatic add_bytes(input int n);
        repeat (n) add_byte(8'($urandom));
    endtask

    task automatic add_code(input logic [15:0] code);
        add_byte(code[15:8]);
        add_byte(code[7:0]);
    endtask

    task automatic add_eth(input logic [15:0] code);
        add_bytes(12);
        add_code(code);
    endtask

    task automatic add_tag(input logic [15:0] code);
        add_bytes(2);
        add_code(code);
    endtask

    task automatic add_gre(input logic [7:0] flags, input logic [15:0] code);
        add_byte(flags);
        add_bytes(1);
        add_code(code);
        add_bytes(4 * (int'(flags[7]) + int'(flags[5]) + int'(flags[4])));
    endtask

    task automatic add_ipv4(input logic [3:0] ihl, input logic [7:0] proto);
        ip_starts.insert(ip_starts.size(), frame_buf.size());
        add_byte({4'h4, ihl});
        add_bytes(1);
        add_code(16'h0000);
        add_bytes(5);
        add_byte(proto);
        add_bytes(((ihl < 5) ? 20 : int'(ihl) * 4) - 10);
    endtask

    task automatic add_tcp(input logic [3:0] doff);
        add_bytes(12);
        add_byte({doff, 4'($urandom)});
        if (int'(doff) * 4 > 13) add_bytes(int'(doff) * 4 - 13);
    endtask

    // a negative length or byte count means the size of the built frame
    task automatic ship_frame(input int fl_in, input int nb_in, input tot_len_mode_t mode);
        int fl;
        int nb;
        int s;
        int ex;
        int r;
        logic [15:0] tl;
        php_pkg::php_in_t it;
        fl = (fl_in < 0) ? frame_buf.size() : fl_in;
        nb = (nb_in < 0) ? frame_buf.size() : nb_in;
        foreach (ip_starts[k]) begin
            s = ip_starts[k];
            ex = (fl > s) ? fl - s : 0;
            r = $urandom_range(99);
            case (mode)
                TL_EXACT: tl = 16'(ex);
                TL_LONG:  tl = 16'(ex + 1);
                default: begin
                    if (r < 60) tl = 16'(ex);
                    else if (r < 75) tl = 16'(ex + $urandom_range(1, 3));
                    else if (r < 90) tl = 16'($urandom_range(0, ex));
                    else tl = 16'($urandom);
                end
            endcase
            if (s + 3 < frame_buf.size()) begin
                frame_buf[s + 2] = tl[15:8];
                frame_buf[s + 3] = tl[7:0];
            end
        end
        for (int i = 0; i < nb; i++) begin
            it.data_byte = (i < frame_buf.size()) ? frame_buf[i] : 8'($urandom);
            it.frame_length = 16'(fl);
            it.last_byte = (i == nb - 1);
            bytes_to_send.insert(bytes_to_send.size(), it);
        end
        frames_sent++;
        bytes_sent += nb;
        frame_buf.delete();
        ip_starts.delete();
    endtask

    function automatic logic [15:0] pick_code();
        case ($urandom_range(0, 11))
            0: return php_pkg::CODE_IPV4;
            1: return php_pkg::CODE_IPIP;
            2: return php_pkg::CODE_ARP;
            3: return php_pkg::CODE_VLAN;
            4: return php_pkg::CODE_MPLS_UC;
            5: return php_pkg::CODE_MPLS_MC;
            6: return php_pkg::CODE_GRE;
            7: return php_pkg::CODE_ICMP;
            8: return php_pkg::CODE_TCP;
            9: return php_pkg::CODE_UDP;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic logic [3:0] pick_len();
        if ($urandom_range(99) < 85) return 4'($urandom_range(5, 8));
        return 4'($urandom_range(0, 15));
    endfunction

    task automatic build_random_frame();
        logic [15:0] code;
        logic [3:0] hlen;
        int depth;
        int total;
        int fl;
        int nb;
        int r;
        bit done;
        code = pick_code();
        add_eth(code);
        done = 1'b0;
        depth = 0;
        while (!done && depth < 10) begin
            depth++;
            case (code)
                php_pkg::CODE_VLAN: begin
                    code = ($urandom_range(3) == 0) ? php_pkg::CODE_VLAN : pick_code();
                    add_tag(code);
                end
                php_pkg::CODE_MPLS_UC, php_pkg::CODE_MPLS_MC: begin
                    add_bytes(4);
                    code = php_pkg::CODE_IPV4;
                end
                php_pkg::CODE_IPV4, php_pkg::CODE_IPIP: begin
                    code = pick_code();
                    hlen = pick_len();
                    add_ipv4(hlen, code[7:0]);
                    code = {8'h00, code[7:0]};
                    done = (hlen < 5);
                end
                php_pkg::CODE_GRE: begin
                    code = pick_code();
                    add_gre(8'($urandom), code);
                end
                php_pkg::CODE_ARP: begin
                    add_bytes(28);
                    done = 1'b1;
                end
                php_pkg::CODE_ICMP, php_pkg::CODE_UDP: begin
                    add_bytes(8);
                    done = 1'b1;
                end
                php_pkg::CODE_TCP: begin
                    add_tcp(pick_len());
                    done = 1'b1;
                end
                default: done = 1'b1;
            endcase
        end
        add_bytes($urandom_range(0, 16));
        total = frame_buf.size();
        r = $urandom_range(99);
        fl = total;
        nb = total;
        if (r >= 65 && r < 77) fl = $urandom_range(0, total);
        else if (r >= 77 && r < 89) nb = $urandom_range(1, total);
        else if (r >= 89 && r < 95) begin
            fl = total + $urandom_range(1, 30);
            if ($urandom_range(1)) nb = fl;
        end else if (r >= 95) fl = $urandom_range(0, 65535);
        ship_frame(fl, nb, TL_RANDOM);
    endtask

    task automatic random_frames(input int n_bytes, input int n_frames);
        int b0;
        int f0;
        b0 = bytes_sent;
        f0 = frames_sent;
        while (bytes_sent - b0 < n_bytes || frames_sent - f0 < n_frames)
            build_random_frame();
    endtask

    task automatic wait_drained();
        while (bytes_to_send.size() != 0 || s_valid || reports_due.size() != 0)
            @(posedge aclk);
    endtask

    // driver
    always @(negedge aclk) begin
        if (aresetn) begin
            m_ready <= ($urandom_range(99) >= rx_idle_pct);
            if (!s_valid || s_took) begin
                if (bytes_to_send.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
                    s_item <= bytes_to_send.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge aclk) begin
        s_took <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) check_report(m_item);
            if (s_valid && s_ready) predict_item(s_item);
        end
    end

    // watchdog
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) ||
            (bytes_to_send.size() == 0 && !s_valid && reports_due.size() == 0)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, STALL_LIMIT);
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        clear_walk();
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        tx_idle_pct = 31;
        rx_idle_pct = 78;

        // plain chains
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_TCP[7:0]);
        add_tcp(5); add_bytes(10);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_VLAN); add_tag(php_pkg::CODE_IPV4);
        add_ipv4(6, php_pkg::CODE_UDP[7:0]); add_bytes(13);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_MPLS_UC); add_bytes(4);
        add_ipv4(5, php_pkg::CODE_ICMP[7:0]); add_bytes(11);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_MPLS_MC); add_bytes(4); add_ipv4(5, php_pkg::CODE_IPIP[7:0]);
        add_ipv4(5, php_pkg::CODE_UDP[7:0]); add_bytes(8);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_GRE[7:0]);
        add_gre(8'hB0, php_pkg::CODE_IPV4);
        add_ipv4(5, php_pkg::CODE_TCP[7:0]); add_tcp(8); add_bytes(6);
        ship_frame(-1, -1, TL_EXACT);
        // arp with payload, exactly its base length, and too short
        add_eth(php_pkg::CODE_ARP); add_bytes(34); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_ARP); add_bytes(28); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_ARP); add_bytes(20); ship_frame(-1, -1, TL_EXACT);
        // unknown ethertype, bytes past the frame length
        add_eth(CODE_UNKNOWN); add_bytes(10); ship_frame(20, -1, TL_EXACT);
        // ethernet only, short ethernet, empty frame
        add_eth(php_pkg::CODE_IPV4); ship_frame(14, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); ship_frame(10, -1, TL_EXACT);
        add_bytes(1); ship_frame(0, 1, TL_EXACT);
        // truncated ip and malformed lengths
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_UDP[7:0]); add_bytes(20);
        ship_frame(-1, -1, TL_LONG);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(4, php_pkg::CODE_TCP[7:0]); add_bytes(20);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_TCP[7:0]);
        add_tcp(4); add_bytes(10);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_TCP[7:0]); add_tcp(15);
        ship_frame(frame_buf.size() - 30, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_UDP[7:0]); add_bytes(5);
        ship_frame(-1, -1, TL_EXACT);
        // tag stack beyond the counter limit
        add_eth(php_pkg::CODE_VLAN);
        for (int i = 0; i < 17; i++) add_tag((i == 16) ? CODE_STACK_END : php_pkg::CODE_VLAN);
        add_bytes(4);
        ship_frame(-1, -1, TL_EXACT);
        // last byte inside a header
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_TCP[7:0]); add_tcp(5);
        ship_frame(-1, 30, TL_EXACT);
        // fields beyond the frame end
        add_eth(php_pkg::CODE_IPV4); add_bytes(2); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_MPLS_UC); add_bytes(3); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_TCP[7:0]); add_bytes(10);
        ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_GRE); add_gre(8'hB0, php_pkg::CODE_IPV4);
        ship_frame(frame_buf.size() - 4, -1, TL_EXACT);
        add_eth(php_pkg::CODE_GRE); add_bytes(4); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_VLAN); add_bytes(3); ship_frame(-1, -1, TL_EXACT);
        add_eth(php_pkg::CODE_IPV4); add_ipv4(5, php_pkg::CODE_UDP[7:0]);
        ship_frame(65535, -1, TL_EXACT);

        random_frames(250, 3);
        wait_drained();

        tx_idle_pct = 78;
        rx_idle_pct = 31;
        random_frames(250, 3);
        wait_drained();

        tx_idle_pct = 0;
        rx_idle_pct = 0;
        random_frames(250, 3);
        wait_drained();

        repeat (20) @(posedge aclk);
        $display("covered %0d frames, %0d bytes, %0d results checked, %0d mismatches",
                 frames_sent, bytes_sent, results_checked, mismatch_count);
        $display("idle profiles: sender 31/78/0 percent, receiver 78/31/0 percent");
        if (mismatch_count == 0 && reports_due.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
